>>> design/cbcv_pkg.sv
package cbcv_pkg;

  // Block geometry of the chained CRC.
  localparam int unsigned BlockBytes = 65536;
  localparam int unsigned BlkCntW    = $clog2(BlockBytes);

  // CRC-32/MPEG-2 definition.
  localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgRegionSize  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgExpectedCrc = CfgIdxW'(1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       read_fail;
  } item_t;

  typedef struct packed {
    logic        passed;
    logic        read_failed;
    logic [31:0] final_crc;
  } result_t;

  typedef struct packed {
    logic [31:0] region_size;
    logic [31:0] expected_crc;
  } cfg_t;

  // One byte into an MSB-first CRC register, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // Contribution of bit i of the register after 32 bit steps: x^(32+i) mod P.
  // Only ever called with a constant index, so it folds to a constant.
  function automatic logic [31:0] crc_col(input int i);
    logic [31:0] c;
    c = '0;
    c[i] = 1'b1;
    for (int k = 0; k < 32; k++) begin
      c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // Start value of a chained block: a fresh CRC that has absorbed the previous
  // block CRC as four bytes, most significant first. Absorbing a whole word
  // MSB-first equals XORing it into the register and shifting 32 times, which
  // is linear, so it becomes one XOR matrix.
  function automatic logic [31:0] chain_seed(input logic [31:0] prev_crc);
    logic [31:0] t;
    logic [31:0] s;
    t = CrcInit ^ prev_crc;
    s = '0;
    for (int i = 0; i < 32; i++) begin
      if (t[i]) begin
        s = s ^ crc_col(i);
      end
    end
    return s;
  endfunction

endpackage

>>> design/cbcv_if.sv
// Input byte stream channel.
interface cbcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       read_fail;

  modport source (output valid, output data_byte, output read_fail, input ready);
  modport sink   (input valid, input data_byte, input read_fail, output ready);
endinterface

// Result channel.
interface cbcv_out_if;
  logic        valid;
  logic        ready;
  logic        passed;
  logic        read_failed;
  logic [31:0] final_crc;

  modport source (output valid, output passed, output read_failed, output final_crc,
                  input ready);
  modport sink   (input valid, input passed, input read_failed, input final_crc,
                  output ready);
endinterface

// Configuration write channel.
interface cbcv_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> design/cbcv_cfg_regs.sv
module cbcv_cfg_regs
  import cbcv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_idx_i,
  input  logic [31:0]        wr_data_i,
  output cfg_t               cfg_o
);

  logic [31:0] region_size_q;
  logic [31:0] expected_crc_q;

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_size_q  <= 32'd1;
      expected_crc_q <= 32'd0;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        CfgRegionSize:  region_size_q  <= wr_data_i;
        CfgExpectedCrc: expected_crc_q <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.region_size  = region_size_q;
  assign cfg_o.expected_crc = expected_crc_q;

endmodule

>>> design/cbcv_core.sv
module cbcv_core
  import cbcv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_en_i,
  input  item_t   item_i,
  input  logic    res_take_i,
  output logic    res_vld_o,
  output result_t res_o
);

  logic [31:0]        crc_q, crc_d;
  logic [31:0]        bytes_q, bytes_d;
  logic [BlkCntW-1:0] blk_cnt_q, blk_cnt_d;
  logic               chain_q, chain_d;
  logic [31:0]        last_q, last_d;
  logic               res_vld_q, res_vld_d;
  result_t            res_q, res_d;

  logic [31:0] crc_start;
  logic [31:0] crc_new;
  logic [31:0] bytes_next;
  logic        region_end;
  logic        blk_end;

  // Byte update: a new block starts fresh or from the chained seed.
  always_comb begin
    if (blk_cnt_q == '0) begin
      crc_start = chain_q ? chain_seed(last_q) : CrcInit;
    end else begin
      crc_start = crc_q;
    end
    crc_new    = crc_byte(crc_start, item_i.data_byte);
    bytes_next = bytes_q + 32'd1;
    region_end = (bytes_next >= cfg_i.region_size);
    blk_end    = region_end || (blk_cnt_q == BlkCntW'(BlockBytes - 1));
  end

  // Next state and result.
  always_comb begin
    crc_d     = crc_q;
    bytes_d   = bytes_q;
    blk_cnt_d = blk_cnt_q;
    chain_d   = chain_q;
    last_d    = last_q;
    res_vld_d = res_vld_q && !res_take_i;
    res_d     = res_q;
    if (item_en_i) begin
      if (item_i.read_fail || region_end) begin
        res_vld_d         = 1'b1;
        res_d.read_failed = item_i.read_fail;
        res_d.final_crc   = item_i.read_fail ? last_q : crc_new;
        res_d.passed      = !item_i.read_fail && (crc_new == cfg_i.expected_crc);
        crc_d     = CrcInit;
        bytes_d   = '0;
        blk_cnt_d = '0;
        chain_d   = 1'b0;
        last_d    = '0;
      end else begin
        crc_d   = crc_new;
        bytes_d = bytes_next;
        if (blk_end) begin
          blk_cnt_d = '0;
          chain_d   = 1'b1;
          last_d    = crc_new;
        end else begin
          blk_cnt_d = blk_cnt_q + BlkCntW'(1);
        end
      end
    end
  end

  // Region state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= CrcInit;
      bytes_q   <= '0;
      blk_cnt_q <= '0;
      chain_q   <= 1'b0;
      last_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      crc_q     <= crc_d;
      bytes_q   <= bytes_d;
      blk_cnt_q <= blk_cnt_d;
      chain_q   <= chain_d;
      last_q    <= last_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule

>>> design/chained_block_crc32_verifier.sv
// Chained-block CRC-32/MPEG-2 region verifier. Region bytes arrive one per
// transaction on the input channel, and one transaction is accepted every clock
// cycle as long as the result register is free or being emptied. Each byte passes
// an input register and then XOR logic that updates the running CRC, and the
// result for the byte that ends the region (or the read failure item) is held
// in the result register that drives the output channel. Every 65536 bytes the
// block CRC is closed and the next block starts from a CRC that has already
// absorbed it; that four-byte prefix is one fixed combinational XOR matrix.
// Configuration writes are accepted in every cycle and should only be issued
// while no input transaction or result is in flight.
module chained_block_crc32_verifier
  import cbcv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cbcv_in_if.sink     in_ch,
  cbcv_out_if.source  out_ch,
  cbcv_cfg_if.sink    cfg_ch
);

  logic    in_vld_q;
  item_t   in_item_q;
  logic    advance;
  logic    res_vld;
  result_t res;
  cfg_t    cfg;

  // The core stage moves on whenever its result register can take a result.
  assign advance      = !res_vld || out_ch.ready;
  assign in_ch.ready  = !in_vld_q || advance;
  assign cfg_ch.ready = 1'b1;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_q.data_byte <= in_ch.data_byte;
      in_item_q.read_fail <= in_ch.read_fail;
    end
  end

  cbcv_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_ch.valid),
    .wr_idx_i  (cfg_ch.index),
    .wr_data_i (cfg_ch.wdata),
    .cfg_o     (cfg)
  );

  cbcv_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .item_en_i  (in_vld_q && advance),
    .item_i     (in_item_q),
    .res_take_i (out_ch.ready),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  assign out_ch.valid       = res_vld;
  assign out_ch.passed      = res.passed;
  assign out_ch.read_failed = res.read_failed;
  assign out_ch.final_crc   = res.final_crc;

endmodule
